### hw/rtl/uart_frame_receiver_core_defines.svh
// Assertion macros shared by the checker of the frame receiver.
// The macros rely on signals named clk and rst in the scope where they are used.
`ifndef UART_FRAME_RECEIVER_CORE_DEFINES_SVH
`define UART_FRAME_RECEIVER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ufr_pkg.sv
// Shared constants, types and helper functions of the frame receiver.
// Used by the RTL modules of the block apart from the store; depends on nothing.
package ufr_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  // The longest body is two header-free bytes plus 62 data bytes.
  localparam int LEN_W       = 7;
  localparam int MAX_PAYLOAD = (62 < STORE_DEPTH - 2) ? 62 : STORE_DEPTH - 2;

  localparam int APB_ADDR_W  = 5;
  localparam int REG_IDX_W   = 3;

  localparam logic [REG_IDX_W-1:0] REG_HEADER_FIRST  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEADER_SECOND = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FOOTER_VALUE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_MODE    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PAYLOAD_LEN   = 3'd4;

  localparam logic [5:0] PAYLOAD_LEN_RESET = 6'd9;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] footer_value;
    logic       frame_mode;
    logic [5:0] payload_len;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_t;

  typedef struct packed {
    logic             push;
    logic [LEN_W-1:0] len;
  } cmd_t;

  // Payload length as actually used: zero counts as one, large values saturate.
  function automatic logic [5:0] eff_payload(input logic [5:0] plen);
    logic [5:0] n;
    n = plen;
    if (n == 6'd0) begin
      n = 6'd1;
    end
    if (n > 6'(MAX_PAYLOAD)) begin
      n = 6'(MAX_PAYLOAD);
    end
    return n;
  endfunction

endpackage

### hw/rtl/ufr_rx_if.sv
// Valid/ready channel carrying received bytes into the frame receiver.
// Stands alone; no package needed.
interface ufr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/ufr_frame_if.sv
// Valid/ready channel carrying frame body bytes out of the frame receiver.
// Stands alone; no package needed.
interface ufr_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

### hw/rtl/uart_frame_receiver_core.sv
// Frame receiver: takes one received byte per handshake and hunts for frames made
// of two header bytes, a body and a footer byte; on a good footer the body is sent
// out word by word with the last one flagged. A byte is normally taken every cycle;
// while a finished frame is still being sent, header bytes are still taken, but any
// later byte of the next frame, footer included, waits until the body has drained.
// The emitter reads the store in the cycle before it loads the output register, and
// the read of the next word overlaps the handshake of the current one, so each word
// passes through a load state and a show state, and valid drops between words.
// The store has no clearing pass after reset. Registers sit on the APB port at
// byte address 4*i. Depends on ufr_pkg, the two channel interfaces and the ufr_*
// submodules.
module uart_frame_receiver_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ufr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  ufr_rx_if.sink                         rx,
  ufr_frame_if.source                    frame
);

  ufr_pkg::cfg_t                 cfg;
  ufr_pkg::wr_t                  wr;
  ufr_pkg::rd_t                  rd;
  ufr_pkg::cmd_t                 cmd;
  logic                          pending;
  logic                          pop;
  logic [ufr_pkg::LEN_W-1:0]     head_len;
  logic [7:0]                    rd_data;
  logic [ufr_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[ufr_pkg::APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first  <= 8'd0;
      cfg.header_second <= 8'd0;
      cfg.footer_value  <= 8'd0;
      cfg.frame_mode    <= 1'b0;
      cfg.payload_len   <= ufr_pkg::PAYLOAD_LEN_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        ufr_pkg::REG_HEADER_FIRST:  cfg.header_first  <= pwdata[7:0];
        ufr_pkg::REG_HEADER_SECOND: cfg.header_second <= pwdata[7:0];
        ufr_pkg::REG_FOOTER_VALUE:  cfg.footer_value  <= pwdata[7:0];
        ufr_pkg::REG_FRAME_MODE:    cfg.frame_mode    <= pwdata[0];
        ufr_pkg::REG_PAYLOAD_LEN:   cfg.payload_len   <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ufr_pkg::REG_HEADER_FIRST:  prdata = {24'd0, cfg.header_first};
      ufr_pkg::REG_HEADER_SECOND: prdata = {24'd0, cfg.header_second};
      ufr_pkg::REG_FOOTER_VALUE:  prdata = {24'd0, cfg.footer_value};
      ufr_pkg::REG_FRAME_MODE:    prdata = {31'd0, cfg.frame_mode};
      ufr_pkg::REG_PAYLOAD_LEN:   prdata = {26'd0, cfg.payload_len};
      default:                    prdata = 32'd0;
    endcase
  end

  ufr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .cfg     (cfg),
    .pending (pending),
    .wr      (wr),
    .cmd     (cmd)
  );

  ufr_store #(
    .DEPTH (ufr_pkg::STORE_DEPTH),
    .WIDTH (8)
  ) u_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (rd_data)
  );

  ufr_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .pop      (pop),
    .pending  (pending),
    .head_len (head_len)
  );

  ufr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pending  (pending),
    .head_len (head_len),
    .pop      (pop),
    .rd       (rd),
    .rd_data  (rd_data),
    .frame    (frame)
  );

endmodule

### hw/rtl/ufr_store.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the frame body bytes; depends on nothing.
module ufr_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/ufr_front.sv
// Front end of the frame receiver: parses incoming bytes, writes the frame body
// into the store and queues an emit command on a good footer. Uses ufr_pkg.
module ufr_front (
  input  logic              clk,
  input  logic              rst,
  ufr_rx_if.sink            rx,
  input  ufr_pkg::cfg_t     cfg,
  input  logic              pending,
  output ufr_pkg::wr_t      wr,
  output ufr_pkg::cmd_t     cmd
);

  localparam logic [2:0] PH_HEAD1  = 3'd0;
  localparam logic [2:0] PH_HEAD2  = 3'd1;
  localparam logic [2:0] PH_TYPE   = 3'd2;
  localparam logic [2:0] PH_COUNT  = 3'd3;
  localparam logic [2:0] PH_LENGTH = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_FOOTER = 3'd6;

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [5:0] data_counter;
  logic [5:0] data_counter_next;
  logic       accept;
  logic       body_phase;
  logic       wr_req;
  logic [6:0] widx;
  logic [5:0] eff_len;

  // Phases that touch the store, and the footer phase, must wait until the previous frame has drained.
  assign body_phase = (phase == PH_TYPE) || (phase == PH_COUNT) || (phase == PH_LENGTH) ||
                      (phase == PH_DATA) || (phase == PH_FOOTER);
  assign rx.ready   = !(pending && body_phase);
  assign accept     = rx.valid && rx.ready;
  assign eff_len    = ufr_pkg::eff_payload(cfg.payload_len);

  always_comb begin
    phase_next        = phase;
    data_counter_next = data_counter;
    wr_req            = 1'b0;
    widx              = 7'd0;
    cmd.push          = 1'b0;
    cmd.len           = '0;
    if (accept) begin
      unique case (phase)
        PH_HEAD2: begin
          if (rx.rx_byte == cfg.header_second) begin
            phase_next = cfg.frame_mode ? PH_TYPE : PH_COUNT;
          end else begin
            phase_next = PH_HEAD1;
          end
        end
        PH_TYPE: begin
          data_counter_next = 6'd0;
          wr_req            = 1'b1;
          widx              = 7'd0;
          phase_next        = PH_COUNT;
        end
        PH_COUNT: begin
          wr_req = 1'b1;
          if (cfg.frame_mode) begin
            widx       = 7'd1;
            phase_next = PH_FOOTER;
          end else begin
            widx       = 7'd0;
            phase_next = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          wr_req            = 1'b1;
          widx              = 7'd1;
          data_counter_next = 6'd0;
          phase_next        = PH_DATA;
        end
        PH_DATA: begin
          wr_req            = 1'b1;
          widx              = {1'b0, data_counter} + 7'd2;
          data_counter_next = data_counter + 6'd1;
          if (data_counter_next >= eff_len) begin
            phase_next = PH_FOOTER;
          end
        end
        PH_FOOTER: begin
          if (rx.rx_byte == cfg.footer_value) begin
            cmd.push = 1'b1;
            cmd.len  = cfg.frame_mode ? 7'd2 : 7'd2 + {1'b0, eff_len};
          end
          phase_next        = PH_HEAD1;
          data_counter_next = 6'd0;
        end
        default: begin
          // The hunt for the first header, also reached from the unused code.
          if (rx.rx_byte == cfg.header_first) begin
            phase_next = PH_HEAD2;
          end else begin
            phase_next = PH_HEAD1;
          end
        end
      endcase
    end
  end

  always_comb begin
    wr.en   = wr_req && (32'(widx) < ufr_pkg::STORE_DEPTH);
    wr.addr = ufr_pkg::ADDR_W'(widx);
    wr.data = rx.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEAD1;
      data_counter <= 6'd0;
    end else begin
      phase        <= phase_next;
      data_counter <= data_counter_next;
    end
  end

endmodule

### hw/rtl/ufr_cmd_queue.sv
// Two-entry queue of emit commands between the parser and the emitter.
// An entry stays until its whole frame has been handed out. Uses ufr_pkg.
module ufr_cmd_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  ufr_pkg::cmd_t             cmd,
  input  logic                      pop,
  output logic                      pending,
  output logic [ufr_pkg::LEN_W-1:0] head_len
);

  logic [ufr_pkg::LEN_W-1:0] slot [2];
  logic                      rd_ptr;
  logic                      wr_ptr;
  logic [1:0]                count;
  logic                      do_push;
  logic                      do_pop;

  assign pending  = (count != 2'd0);
  assign head_len = slot[rd_ptr];
  assign do_push  = cmd.push && (count != 2'd2);
  assign do_pop   = pop && pending;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= cmd.len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### hw/rtl/ufr_back.sv
// Back end of the frame receiver: reads the stored body byte by byte and drives
// the output channel through a holding register. Uses ufr_pkg.
module ufr_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pending,
  input  logic [ufr_pkg::LEN_W-1:0] head_len,
  output logic                      pop,
  output ufr_pkg::rd_t              rd,
  input  logic [7:0]                rd_data,
  ufr_frame_if.source               frame
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_SHOW = 2'd2;

  logic [1:0]                state;
  logic [ufr_pkg::LEN_W-1:0] idx;
  logic [ufr_pkg::LEN_W-1:0] idx_inc;
  logic [7:0]                byte_q;
  logic                      last_q;
  logic                      valid_q;

  assign idx_inc          = idx + 1'b1;
  assign frame.valid      = valid_q;
  assign frame.frame_byte = byte_q;
  assign frame.frame_last = last_q;

  always_comb begin
    pop     = 1'b0;
    rd.en   = 1'b0;
    rd.addr = ufr_pkg::ADDR_W'(idx);
    unique case (state)
      S_IDLE: begin
        rd.en = pending;
      end
      S_SHOW: begin
        if (frame.ready) begin
          if (last_q) begin
            pop = 1'b1;
          end else begin
            rd.en   = 1'b1;
            rd.addr = ufr_pkg::ADDR_W'(idx_inc);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      byte_q <= rd_data;
      last_q <= (idx_inc == head_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      valid_q <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pending) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          valid_q <= 1'b1;
          state   <= S_SHOW;
        end
        S_SHOW: begin
          if (frame.ready) begin
            valid_q <= 1'b0;
            if (last_q) begin
              idx   <= '0;
              state <= S_IDLE;
            end else begin
              idx   <= idx_inc;
              state <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/ufr_checker.sv
// Port-level checker for the frame receiver, attached to the top level by bind.
// Uses the assertion macros of the defines header and ufr_pkg for widths.
`include "uart_frame_receiver_core_defines.svh"

module ufr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           frame_valid,
  input logic                           frame_ready,
  input logic [7:0]                     frame_byte,
  input logic                           frame_last,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [ufr_pkg::APB_ADDR_W-1:0] paddr,
  input logic [31:0]                    prdata,
  input logic                           pready
);

  // A word waiting at the output keeps its value until it is taken.
  `UFR_ASSERT_NEXT(a_out_hold, frame_valid && !frame_ready, frame_valid && $stable(frame_byte) && $stable(frame_last), "output word changed while stalled")

  // Every word needs a fresh store read, so valid always drops after a handshake.
  `UFR_ASSERT_NEXT(a_out_gap, frame_valid && frame_ready, !frame_valid, "output valid did not drop after a handshake")

  `UFR_ASSERT_NOW(a_pready, 1'b1, pready, "pready went low")

  // Register contents only change through a completed write.
  `UFR_ASSERT_NOW(a_prdata_stable, !(psel && penable && pwrite) ##1 $stable(paddr), $stable(prdata), "read data changed without a write")

endmodule

bind uart_frame_receiver_core ufr_checker u_ufr_checker (
  .clk         (clk),
  .rst         (rst),
  .frame_valid (frame.valid),
  .frame_ready (frame.ready),
  .frame_byte  (frame.frame_byte),
  .frame_last  (frame.frame_last),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .prdata      (prdata),
  .pready      (pready)
);

### verif/uart_frame_receiver_core_test.sv
// Self-checking test of the frame receiver core: bytes in over the receive channel,
// frame body words out, registers set over APB between phases.
// Depends on ufr_pkg, ufr_rx_if, ufr_frame_if and uart_frame_receiver_core.
module uart_frame_receiver_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ufr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned PHASE_ITEMS   = 20;
  localparam int unsigned PHASES        = 8;

  typedef enum logic [2:0] {
    HUNT_FIRST,
    SEEK_SECOND,
    TAKE_TYPE,
    TAKE_COUNT,
    TAKE_LENGTH,
    TAKE_DATA,
    AWAIT_FOOTER
  } parse_state_e;

  typedef enum int {FR_GOOD, FR_BAD_SECOND, FR_BAD_FOOTER, FR_CUT, FR_NOISE} frame_kind_e;
  typedef enum int {READY_ALWAYS, READY_COIN, READY_PATTERN} ready_style_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  // Tracks the parser and the body store, and queues the words each byte releases.
  class frame_scoreboard;
    logic [7:0]   hdr1;
    logic [7:0]   hdr2;
    logic [7:0]   ftr;
    logic         mode;
    logic [5:0]   plen;
    parse_state_e state;
    logic [5:0]   cnt;
    logic [7:0]   body_mem [STORE_DEPTH];
    frame_word_t  want_q [$];
    int unsigned  errors;

    function new();
      hdr1   = 8'h00;
      hdr2   = 8'h00;
      ftr    = 8'h00;
      mode   = 1'b0;
      plen   = PAYLOAD_LEN_RESET;
      state  = HUNT_FIRST;
      cnt    = 6'd0;
      errors = 0;
    endfunction

    function int unsigned data_len();
      int unsigned n;
      n = plen;
      if (n == 0) begin
        n = 1;
      end
      if (n > MAX_PAYLOAD) begin
        n = MAX_PAYLOAD;
      end
      return n;
    endfunction

    function int unsigned pending();
      return want_q.size();
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_HEADER_FIRST:  hdr1 = value[7:0];
        REG_HEADER_SECOND: hdr2 = value[7:0];
        REG_FOOTER_VALUE:  ftr  = value[7:0];
        REG_FRAME_MODE:    mode = value[0];
        REG_PAYLOAD_LEN:   plen = value[5:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned n;
      int unsigned idx;
      case (state)
        SEEK_SECOND: begin
          if (b != hdr2) begin
            state = HUNT_FIRST;
          end else if (mode) begin
            state = TAKE_TYPE;
          end else begin
            state = TAKE_COUNT;
          end
        end
        TAKE_TYPE: begin
          cnt = 6'd0;
          body_mem[0] = b;
          state = TAKE_COUNT;
        end
        TAKE_COUNT: begin
          if (mode) begin
            body_mem[1] = b;
            state = AWAIT_FOOTER;
          end else begin
            body_mem[0] = b;
            state = TAKE_LENGTH;
          end
        end
        TAKE_LENGTH: begin
          body_mem[1] = b;
          cnt = 6'd0;
          state = TAKE_DATA;
        end
        TAKE_DATA: begin
          idx = cnt + 2;
          if (idx < STORE_DEPTH) begin
            body_mem[idx] = b;
          end
          cnt = cnt + 6'd1;
          // The length is looked at afresh on every data byte.
          if (cnt >= data_len()) begin
            state = AWAIT_FOOTER;
          end
        end
        AWAIT_FOOTER: begin
          if (b == ftr) begin
            n = mode ? 2 : 2 + data_len();
            for (int i = 0; i < n; i++) begin
              want_q.push_back('{data: body_mem[i], last: (i + 1 == n)});
            end
          end
          state = HUNT_FIRST;
          cnt = 6'd0;
        end
        default: begin
          if (b == hdr1) begin
            state = SEEK_SECOND;
          end else begin
            state = HUNT_FIRST;
          end
        end
      endcase
    endfunction

    function void check_word(logic [7:0] data, logic last);
      frame_word_t w;
      if (want_q.size() == 0) begin
        $error("frame word with none expected: frame_byte %02h frame_last %0b", data, last);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (data !== w.data) begin
        $error("frame_byte: expected %02h, got %02h", w.data, data);
        errors++;
      end
      if (last !== w.last) begin
        $error("frame_last: expected %0b, got %0b", w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  ufr_rx_if    rx_ch ();
  ufr_frame_if frame_ch ();

  frame_scoreboard sb = new();

  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_requests = 0;

  uart_frame_receiver_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx      (rx_ch),
    .frame   (frame_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Output side: checks each accepted word and stalls in styles of its own.
  initial begin
    ready_style_e style;
    int unsigned  style_left;
    int unsigned  hold_left;
    int unsigned  holds_served;
    logic         take;
    style        = READY_ALWAYS;
    style_left   = 0;
    hold_left    = 0;
    holds_served = 0;
    frame_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) begin
        sb.check_word(frame_ch.frame_byte, frame_ch.frame_last);
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (style_left == 0) begin
        style = ready_style_e'($urandom_range(0, 2));
        style_left = $urandom_range(40, 300);
      end
      style_left--;
      case (style)
        READY_ALWAYS: take = 1'b1;
        READY_COIN:   take = 1'($urandom_range(0, 1));
        default:      take = (style_left % 7) < 3;
      endcase
      if (hold_left != 0) begin
        take = 1'b0;
        hold_left--;
      end
      frame_ch.ready <= take;
    end
  end

  function automatic logic [7:0] other_than(logic [7:0] v);
    return v ^ (8'd1 << $urandom_range(0, 7));
  endfunction

  task automatic stop_sending();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one byte; the sender runs in bursts with idle gaps between them.
  task automatic put_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    sb.note_byte(b);
    burst_left--;
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] hf, input logic [7:0] hs, input logic [7:0] ft,
                           input logic md, input logic [5:0] pl);
    reg_write(REG_HEADER_FIRST, 32'(hf));
    reg_write(REG_HEADER_SECOND, 32'(hs));
    reg_write(REG_FOOTER_VALUE, 32'(ft));
    reg_write(REG_FRAME_MODE, 32'(md));
    reg_write(REG_PAYLOAD_LEN, 32'(pl));
  endtask

  // Waits for every expected word, then lets any byte still inside the block settle.
  task automatic settle();
    stop_sending();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Brings the parser back to the header hunt without emitting anything.
  task automatic finish_frame();
    while (sb.state != HUNT_FIRST) begin
      if (sb.state == SEEK_SECOND) begin
        put_byte(other_than(sb.hdr2));
      end else if (sb.state == AWAIT_FOOTER) begin
        put_byte(other_than(sb.ftr));
      end else begin
        put_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic send_frame(input frame_kind_e kind, output int unsigned sent);
    logic [7:0]  q [$];
    int unsigned keep;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
      sent = 0;
      return;
    end
    q.push_back(sb.hdr1);
    if (kind == FR_BAD_SECOND) begin
      q.push_back(($urandom_range(0, 1) == 0) ? sb.hdr1 : other_than(sb.hdr2));
    end else begin
      q.push_back(sb.hdr2);
      q.push_back(8'($urandom_range(0, 255)));
      q.push_back(8'($urandom_range(0, 255)));
      if (!sb.mode) begin
        repeat (sb.data_len()) q.push_back(8'($urandom_range(0, 255)));
      end
      q.push_back((kind == FR_BAD_FOOTER) ? other_than(sb.ftr) : sb.ftr);
      if (kind == FR_CUT) begin
        keep = $urandom_range(1, q.size() - 1);
        while (q.size() > keep) void'(q.pop_back());
      end
    end
    sent = q.size();
    foreach (q[i]) put_byte(q[i]);
  endtask

  initial begin
    logic [7:0]  seq [$];
    logic [7:0]  hf;
    logic [7:0]  hs;
    logic [7:0]  ft;
    logic        md;
    logic [5:0]  pl;
    int unsigned sent;
    int unsigned total;
    int unsigned pick;
    frame_kind_e kind;
    bit          paused;

    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Long frames: a good one with extreme bytes, a second header that repeats the
    // first, and a frame closed by the wrong footer.
    configure(8'hA5, 8'h5A, 8'h7E, 1'b0, 6'd3);
    seq = '{8'hA5, 8'h5A, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'hFF, 8'h7E,
            8'hA5, 8'hA5,
            8'hA5, 8'h5A, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h00};
    foreach (seq[i]) put_byte(seq[i]);

    // Short frames, then a frame that changes mode after its second header and has
    // its length cut to zero, which counts as one, part way through the data.
    finish_frame();
    settle();
    configure(8'hFF, 8'h00, 8'hFF, 1'b1, 6'd3);
    seq = '{8'hFF, 8'h00, 8'h01, 8'h02, 8'h00,
            8'hFF, 8'h00, 8'hAA, 8'h55, 8'hFF,
            8'hFF, 8'h00};
    foreach (seq[i]) put_byte(seq[i]);
    settle();
    reg_write(REG_FRAME_MODE, 32'd0);
    seq = '{8'h12, 8'h34, 8'h56, 8'h78};
    foreach (seq[i]) put_byte(seq[i]);
    settle();
    reg_write(REG_PAYLOAD_LEN, 32'd0);
    seq = '{8'h9A, 8'hFF};
    foreach (seq[i]) put_byte(seq[i]);

    for (int p = 0; p < PHASES; p++) begin
      finish_frame();
      settle();
      hf = 8'($urandom_range(0, 255));
      hs = 8'($urandom_range(0, 255));
      ft = 8'($urandom_range(0, 255));
      md = 1'($urandom_range(0, 1));
      pl = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 6));
      case (p)
        0: begin
          // A length above the limit saturates: the longest body there is.
          hf = 8'h00;
          hs = 8'hFF;
          ft = 8'h00;
          md = 1'b0;
          pl = 6'd63;
        end
        1: begin
          hf = 8'hFF;
          hs = 8'hFF;
          ft = 8'hFF;
          md = 1'b1;
          pl = 6'd1;
        end
        2: begin
          md = 1'b0;
          pl = 6'(MAX_PAYLOAD);
        end
        default: ;
      endcase
      configure(hf, hs, ft, md, pl);
      // The output side holds off for a long stretch so that the block backs up.
      if (p == 3) begin
        hold_requests++;
      end
      total = 0;
      paused = 1'b0;
      while (total < PHASE_ITEMS) begin
        if (p == 5 && total >= PHASE_ITEMS / 2 && !paused) begin
          settle();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 66) begin
          kind = FR_GOOD;
        end else if (pick < 75) begin
          kind = FR_BAD_SECOND;
        end else if (pick < 84) begin
          kind = FR_BAD_FOOTER;
        end else if (pick < 92) begin
          kind = FR_CUT;
        end else begin
          kind = FR_NOISE;
        end
        send_frame(kind, sent);
        total += sent;
      end
    end

    settle();
    repeat (32) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/ufr_pkg.sv
hw/rtl/ufr_rx_if.sv
hw/rtl/ufr_frame_if.sv
hw/rtl/ufr_store.sv
hw/rtl/ufr_front.sv
hw/rtl/ufr_cmd_queue.sv
hw/rtl/ufr_back.sv
hw/rtl/uart_frame_receiver_core.sv
hw/rtl/ufr_checker.sv
verif/uart_frame_receiver_core_test.sv
